@@ rtl/core/history_record_deframer_defines.svh @@
// -----------------------------------------------------------------------------
// History record deframer assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef HISTORY_RECORD_DEFRAMER_DEFINES_SVH
`define HISTORY_RECORD_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define HRD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define HRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HRD_ASSERT(lbl, expr, msg)
`define HRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/hrd_pkg.sv @@
// -----------------------------------------------------------------------------
// History record deframer package
// Beat types, classification record and format constants.
// -----------------------------------------------------------------------------
package hrd_pkg;

	localparam int MAX_TURNS_DEF   = 8;
	localparam int TEXT_MAX_DEF    = 1024;
	localparam int MAX_BYTES_DEF   = 16384;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int POS_W = 15;
	localparam logic [POS_W-1:0] POS_TOP = '1;
	localparam logic [2:0] PERSONA_MAX = 3'd4;
	localparam int HDR_LEN = 8;

	localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h4D, 8'h48, 8'h31};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_valid;
		logic [2:0] text_turn;
		logic       text_role;
		logic       text_end;
		logic       msg_done;
		logic       msg_status;
		logic [3:0] turn_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
		logic       is_zero;
		logic       turns_bad;
		logic [3:0] magic_hit;
	} cls_t;

endpackage

@@ rtl/core/hrd_front.sv @@
// -----------------------------------------------------------------------------
// History record deframer front end
// Accepts input beats, classifies each byte and pushes it into the queue.
// -----------------------------------------------------------------------------
module hrd_front import hrd_pkg::*; #(
	parameter int MAX_TURNS = MAX_TURNS_DEF
) (
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	input  logic     q_full,
	output logic     q_push,
	output cls_t     q_data
);

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_data.in_byte   = item.in_byte;
		q_data.in_last   = item.in_last;
		q_data.is_zero   = (item.in_byte == 8'd0);
		q_data.turns_bad = ({1'b0, item.in_byte} > 9'(MAX_TURNS));
		for (int i = 0; i < 4; i++) begin
			q_data.magic_hit[i] = (item.in_byte == MAGIC[i]);
		end
	end

endmodule

@@ rtl/core/hrd_fifo.sv @@
// -----------------------------------------------------------------------------
// History record deframer queue
// Short first-in first-out buffer between front end and parser.
// -----------------------------------------------------------------------------
`include "history_record_deframer_defines.svh"

module hrd_fifo import hrd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cls_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cls_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`HRD_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`HRD_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")
	`HRD_ASSERT(a_cnt_range, cnt_q <= (AW+1)'(DEPTH), "queue count out of range")
	`HRD_ASSERT_NEXT(a_push_fills, push && !pop, not_empty, "queue empty after push")

endmodule

@@ rtl/core/hrd_back.sv @@
// -----------------------------------------------------------------------------
// History record deframer parser
// Walks header, lengths and texts per byte and holds the result register.
// -----------------------------------------------------------------------------
`include "history_record_deframer_defines.svh"

module hrd_back import hrd_pkg::*; #(
	parameter int TEXT_MAX  = TEXT_MAX_DEF,
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      persona_we,
	input  logic [2:0] persona_wdata,
	input  logic      q_valid,
	input  cls_t      q_data,
	output logic      q_pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_TEXT,
		PH_TAIL
	} phase_t;

	logic [2:0]       persona_q;
	logic [POS_W-1:0] pos_q, pos_n;
	logic             err_q, err_n;
	phase_t           phase_q, phase_n;
	logic [7:0]       hdr_turns_q, hdr_turns_n;
	logic [7:0]       cur_turn_q, cur_turn_n;
	logic             cur_role_q, cur_role_n;
	logic [7:0]       len_high_q, len_high_n;
	logic [15:0]      remaining_q, remaining_n;
	logic [15:0]      text_len;
	logic [15:0]      rem_dec;
	logic             bad;
	logic             take;
	logic             result_valid_q;
	out_item_t        result_q, res_n;

	assign take         = q_valid && (!result_valid_q || !result_stall);
	assign q_pop        = take;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign text_len     = {len_high_q, q_data.in_byte};
	assign rem_dec      = remaining_q - 16'd1;

	always_comb begin
		pos_n       = pos_q;
		err_n       = err_q;
		phase_n     = phase_q;
		hdr_turns_n = hdr_turns_q;
		cur_turn_n  = cur_turn_q;
		cur_role_n  = cur_role_q;
		len_high_n  = len_high_q;
		remaining_n = remaining_q;
		res_n       = '0;
		bad         = 1'b0;

		if (!err_q) begin
			priority if (pos_q >= POS_W'(MAX_BYTES)) begin
				err_n = 1'b1;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						priority if (pos_q < POS_W'(4)) begin
							if (!q_data.magic_hit[pos_q[1:0]]) err_n = 1'b1;
						end else if (pos_q == POS_W'(4)) begin
							if (q_data.turns_bad) err_n = 1'b1;
							hdr_turns_n = q_data.in_byte;
						end else if (pos_q == POS_W'(5)) begin
							if (persona_q > PERSONA_MAX ||
							    q_data.in_byte != {5'd0, persona_q}) err_n = 1'b1;
						end else begin
							if (!q_data.is_zero) begin
								err_n = 1'b1;
							end else if (pos_q == POS_W'(HDR_LEN - 1)) begin
								cur_turn_n = '0;
								cur_role_n = 1'b0;
								phase_n    = (hdr_turns_q == 8'd0) ? PH_TAIL : PH_LEN_HI;
							end
						end
					end
					PH_LEN_HI: begin
						len_high_n = q_data.in_byte;
						phase_n    = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						if (text_len == 16'd0 || {1'b0, text_len} > 17'(TEXT_MAX)) begin
							err_n = 1'b1;
						end else begin
							remaining_n = text_len;
							phase_n     = PH_TEXT;
						end
					end
					PH_TEXT: begin
						if (q_data.is_zero || remaining_q == 16'd0) begin
							err_n = 1'b1;
						end else begin
							res_n.text_byte  = q_data.in_byte;
							res_n.text_valid = 1'b1;
							res_n.text_turn  = cur_turn_q[2:0];
							res_n.text_role  = cur_role_q;
							remaining_n      = rem_dec;
							if (rem_dec == 16'd0) begin
								res_n.text_end = 1'b1;
								if (!cur_role_q) begin
									cur_role_n = 1'b1;
									phase_n    = PH_LEN_HI;
								end else begin
									cur_role_n = 1'b0;
									cur_turn_n = cur_turn_q + 8'd1;
									phase_n    = (cur_turn_n >= hdr_turns_q) ? PH_TAIL
									                                         : PH_LEN_HI;
								end
							end
						end
					end
					PH_TAIL: err_n = 1'b1;
					default: err_n = 1'b1;
				endcase
			end
		end

		if (pos_q != POS_TOP) pos_n = pos_q + 1'b1;

		if (q_data.in_last) begin
			bad              = err_n || (phase_n != PH_TAIL);
			res_n.msg_done   = 1'b1;
			res_n.msg_status = bad;
			res_n.turn_count = bad ? 4'd0 : hdr_turns_n[3:0];
			pos_n       = '0;
			err_n       = 1'b0;
			phase_n     = PH_HEADER;
			hdr_turns_n = '0;
			cur_turn_n  = '0;
			cur_role_n  = 1'b0;
			len_high_n  = '0;
			remaining_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persona_q      <= '0;
			pos_q          <= '0;
			err_q          <= 1'b0;
			phase_q        <= PH_HEADER;
			hdr_turns_q    <= '0;
			cur_turn_q     <= '0;
			cur_role_q     <= 1'b0;
			len_high_q     <= '0;
			remaining_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (persona_we) persona_q <= persona_wdata;
			if (take) begin
				pos_q          <= pos_n;
				err_q          <= err_n;
				phase_q        <= phase_n;
				hdr_turns_q    <= hdr_turns_n;
				cur_turn_q     <= cur_turn_n;
				cur_role_q     <= cur_role_n;
				len_high_q     <= len_high_n;
				remaining_q    <= remaining_n;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) result_q <= res_n;
	end

	`HRD_ASSERT(a_end_has_text, !(result_valid_q && result_q.text_end &&
		!result_q.text_valid), "text end without text byte")
	`HRD_ASSERT(a_count_ok_only, !(result_valid_q && result_q.turn_count != 4'd0 &&
		(!result_q.msg_done || result_q.msg_status)), "turn count without ok status")
	`HRD_ASSERT_NEXT(a_err_sticky, take && err_q && !q_data.in_last, err_q,
		"error cleared inside message")
	`HRD_ASSERT_NEXT(a_last_restarts, take && q_data.in_last,
		pos_q == '0 && phase_q == PH_HEADER && !err_q, "parser not restarted after last beat")

endmodule

@@ rtl/core/history_record_deframer.sv @@
// -----------------------------------------------------------------------------
// History record deframer
// Checks a framed chat history message and streams out its text bytes.
// -----------------------------------------------------------------------------
// One beat in, one result beat out, at one byte per clock while result_stall is
// low. The input beat is classified and written into a four-entry queue; the
// parser takes one queued beat per cycle into its result register when
// result_stall allows, so a result passes the queue and then that register.
// item_stall rises only when the queue is full, which happens when result_stall
// holds off the result register. Text passed out for a message whose final beat
// reports malformed must be thrown away by the consumer. persona_we writes the
// persona; the user must use it only while the block is idle (unchecked).
// -----------------------------------------------------------------------------
module history_record_deframer import hrd_pkg::*; #(
	parameter int MAX_TURNS   = MAX_TURNS_DEF,
	parameter int TEXT_MAX    = TEXT_MAX_DEF,
	parameter int MAX_BYTES   = MAX_BYTES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       persona_we,
	input  logic [2:0] persona_wdata,
	input  logic       item_valid,
	output logic       item_stall,
	input  in_item_t   item,
	output logic       result_valid,
	input  logic       result_stall,
	output out_item_t  result
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	cls_t q_wdata;
	cls_t q_rdata;

	hrd_front #(
		.MAX_TURNS (MAX_TURNS)
	) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	hrd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_rdata)
	);

	hrd_back #(
		.TEXT_MAX  (TEXT_MAX),
		.MAX_BYTES (MAX_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.persona_we    (persona_we),
		.persona_wdata (persona_wdata),
		.q_valid       (q_not_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

endmodule
